[design/char_stream_tokenizer_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CHAR_STREAM_TOKENIZER_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define CST_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define CST_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[design/cst_pkg.sv]
// Shared types, constants and byte-class helpers for the tokenizer.
// No dependencies; imported by every tokenizer module.
`timescale 1ns / 1ps

package cst_pkg;

  localparam int TEXT_SIZE  = 32;
  localparam int BUF_DEPTH  = TEXT_SIZE - 1;
  localparam int LEN_W      = $clog2(TEXT_SIZE);
  localparam int ADDR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int MEM_AW     = ADDR_W + 1;
  localparam int MEM_DEPTH  = 2 ** MEM_AW;
  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PW     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CW     = $clog2(CMD_DEPTH + 1);

  localparam logic [15:0] TOKEN_LIMIT_RESET = 16'd1024;

  localparam int KW_LEN = 5;
  localparam bit KW_OK  = (BUF_DEPTH >= KW_LEN);
  localparam logic [7:0] KW_TEXT [KW_LEN] = '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74};

  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_PRINT    = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_ASSIGN   = 3'd3,
    KIND_OPERATOR = 3'd4,
    KIND_END      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_IDENT  = 2'd1,
    PEND_NUMBER = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_FETCH  = 2'd1,
    B_TEXT   = 2'd2,
    B_SINGLE = 2'd3
  } back_state_t;

  // One queued job: an optional buffered token followed by an optional
  // one-character token (assign, operator or END).
  typedef struct packed {
    logic             flush;
    kind_t            fkind;
    logic [LEN_W-1:0] flen;
    logic             fbank;
    logic             single;
    kind_t            skind;
    logic [7:0]       schar;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_op_char(logic [7:0] c);
    return (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
  endfunction

endpackage

[design/cst_cmd_fifo.sv]
// Short job queue between the tokenizer front and back.
// Depends on cst_pkg (cmd_t, CMD_DEPTH) and the assertion macro header.
`timescale 1ns / 1ps
`include "char_stream_tokenizer_macros.svh"

module cst_cmd_fifo import cst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              entry_r [CMD_DEPTH];
  logic [CMD_PW-1:0] wp_r, wp_nxt;
  logic [CMD_PW-1:0] rp_r, rp_nxt;
  logic [CMD_CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = entry_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wp_r + CMD_PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rp_r + CMD_PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CMD_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CMD_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

  `CST_ASSERT_NEVER(a_fifo_no_overflow, clk, rst_n, push && full, "job pushed into full queue")
  `CST_ASSERT_NEVER(a_fifo_no_underflow, clk, rst_n, pop && empty, "job popped from empty queue")

endmodule

[design/cst_front.sv]
// Tokenizer front: accepts bytes, classifies them, tracks the pending token
// and queues emit jobs. Depends on cst_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_stream_tokenizer_macros.svh"

module cst_front import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  input  logic [15:0] token_limit,
  output logic        cmd_push,
  output cmd_t        cmd_data,
  input  logic        cmd_full,
  output wr_t         mem_wr,
  input  rel_t        rel
);

  pend_t            pend_r, pend_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             cur_r, cur_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             kw_r, kw_nxt;

  logic        let_c, dig_c, cont, append, flush, open, start, is_asg, is_op;
  logic        single, wbank, accept;
  logic [15:0] count_fl;
  kind_t       fkind;

  function automatic logic kw_hit(logic [LEN_W-1:0] pos, logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_LEN; i++) begin
      if (pos == LEN_W'(i) && c == KW_TEXT[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always_comb begin
    let_c    = is_letter(in_byte);
    dig_c    = is_digit(in_byte);
    cont     = (pend_r == PEND_IDENT) ? (let_c || dig_c) : ((pend_r == PEND_NUMBER) && dig_c);
    append   = !in_end_of_input && cont && (len_r < LEN_W'(BUF_DEPTH));
    flush    = (pend_r != PEND_NONE) && !append;
    count_fl = count_r + 16'(flush);
    open     = !in_end_of_input && !append && (count_fl < token_limit);
    start    = open && (let_c || dig_c);
    is_asg   = open && (in_byte == CH_ASSIGN);
    is_op    = open && is_op_char(in_byte);
    single   = in_end_of_input || is_asg || is_op;
    wbank    = flush ? ~cur_r : cur_r;
    // Stall job bytes on a full queue, token starts while the target bank drains.
    in_stall = ((flush || single) && cmd_full) || (start && busy_r[wbank]);
    accept   = in_valid && !in_stall;

    if (pend_r == PEND_IDENT) begin
      fkind = (KW_OK && kw_r && (len_r == LEN_W'(KW_LEN))) ? KIND_PRINT : KIND_IDENT;
    end else begin
      fkind = KIND_NUMBER;
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    kw_nxt    = kw_r;
    busy_nxt  = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (flush) begin
        busy_nxt[cur_r] = 1'b1;
        cur_nxt         = ~cur_r;
      end
      if (in_end_of_input) begin
        pend_nxt  = PEND_NONE;
        len_nxt   = '0;
        count_nxt = '0;
      end else if (append) begin
        len_nxt = len_r + LEN_W'(1);
        kw_nxt  = kw_r && kw_hit(len_r, in_byte);
      end else begin
        count_nxt = count_fl + 16'(is_asg || is_op);
        if (start) begin
          pend_nxt = let_c ? PEND_IDENT : PEND_NUMBER;
          len_nxt  = LEN_W'(1);
          kw_nxt   = (in_byte == KW_TEXT[0]);
        end else begin
          pend_nxt = PEND_NONE;
          len_nxt  = '0;
        end
      end
    end
  end

  always_comb begin
    cmd_push        = accept && (flush || single);
    cmd_data.flush  = flush;
    cmd_data.fkind  = fkind;
    cmd_data.flen   = len_r;
    cmd_data.fbank  = cur_r;
    cmd_data.single = single;
    cmd_data.skind  = in_end_of_input ? KIND_END : (is_asg ? KIND_ASSIGN : KIND_OPERATOR);
    cmd_data.schar  = in_end_of_input ? CH_NUL : in_byte;

    mem_wr.en   = accept && (append || start);
    mem_wr.addr = append ? {cur_r, len_r[ADDR_W-1:0]} : {wbank, {ADDR_W{1'b0}}};
    mem_wr.data = in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      len_r   <= '0;
      count_r <= '0;
      cur_r   <= 1'b0;
      busy_r  <= '0;
      kw_r    <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      busy_r  <= busy_nxt;
      kw_r    <= kw_nxt;
    end
  end

  `CST_ASSERT_NEVER(a_front_no_busy_write, clk, rst_n, mem_wr.en && busy_r[mem_wr.addr[MEM_AW-1]], "text written into a bank still draining")
  `CST_ASSERT_IMPL(a_front_pend_has_len, clk, rst_n, pend_r != PEND_NONE, len_r != '0, "pending token with no buffered text")

endmodule

[design/cst_back.sv]
// Tokenizer back: holds the two-bank text memory, pops jobs and sends one
// result per character through a registered output. Depends on cst_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_stream_tokenizer_macros.svh"

module cst_back import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  wr_t        mem_wr,
  input  logic       cmd_empty,
  input  cmd_t       cmd_head,
  output logic       cmd_pop,
  output rel_t       rel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_last_in_token,
  output logic       out_last_in_run
);

  logic [7:0]       text_mem_r [MEM_DEPTH];
  logic [7:0]       rd_data_r;
  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r;
  logic [LEN_W-1:0] idx_r, idx_nxt, idx_inc;
  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             lt_r, lt_nxt, lr_r, lr_nxt;

  logic              out_free, last_char, load, rd_en;
  logic [MEM_AW-1:0] rd_addr;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_char = (idx_r == cmd_r.flen - LEN_W'(1));
  assign idx_inc   = idx_r + LEN_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = cmd_head.flush ? B_FETCH : B_SINGLE;
        end
      end
      B_FETCH: state_nxt = B_TEXT;
      B_TEXT: begin
        if (out_free && last_char) begin
          state_nxt = cmd_r.single ? B_SINGLE : B_IDLE;
        end
      end
      B_SINGLE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {cmd_r.fbank, idx_inc[ADDR_W-1:0]};
    idx_nxt   = idx_r;
    load      = 1'b0;
    kind_nxt  = kind_r;
    char_nxt  = char_r;
    lt_nxt    = lt_r;
    lr_nxt    = lr_r;
    rel.valid = 1'b0;
    rel.bank  = cmd_r.fbank;
    case (state_r)
      B_IDLE: cmd_pop = !cmd_empty;
      B_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = {cmd_r.fbank, {ADDR_W{1'b0}}};
        idx_nxt = '0;
      end
      B_TEXT: begin
        if (out_free) begin
          load     = 1'b1;
          kind_nxt = cmd_r.fkind;
          char_nxt = rd_data_r;
          lt_nxt   = last_char;
          lr_nxt   = last_char && !cmd_r.single;
          if (last_char) begin
            rel.valid = 1'b1;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = idx_inc;
          end
        end
      end
      B_SINGLE: begin
        if (out_free) begin
          load     = 1'b1;
          kind_nxt = cmd_r.skind;
          char_nxt = cmd_r.schar;
          lt_nxt   = 1'b1;
          lr_nxt   = 1'b1;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_head;
    end
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    char_r <= char_nxt;
    lt_r   <= lt_nxt;
    lr_r   <= lr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      text_mem_r[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= text_mem_r[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_kind    = kind_r;
  assign out_text_char     = char_r;
  assign out_last_in_token = lt_r;
  assign out_last_in_run   = lr_r;

  `CST_ASSERT_IMPL(a_back_idx_in_token, clk, rst_n, state_r == B_TEXT, idx_r < cmd_r.flen, "text read past end of token")
  `CST_ASSERT_IMPL(a_back_run_ends_token, clk, rst_n, out_valid_r && out_last_in_run, out_last_in_token, "run ends inside a token")

endmodule

[design/char_stream_tokenizer.sv]
// Top level of the streaming lexical tokenizer: config register, front,
// job queue and back. Depends on cst_pkg, cst_front, cst_cmd_fifo, cst_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       in         in_valid / in_stall  in_byte[7:0], in_end_of_input
// out_      out        out_valid/out_stall  out_token_kind[2:0], out_text_char[7:0],
//                                           out_last_in_token, out_last_in_run
// cfg_      in         cfg_wr_en            cfg_wr_data[15:0] (token limit)
//
// Flow: the back takes each job off the queue in B_IDLE; a finished token then costs
// one memory fetch and one result per character, and an assign, operator or END
// result one more. With the back idle, a single result goes through B_IDLE and
// B_SINGLE into the output register, token text through B_IDLE, B_FETCH and
// B_TEXT.
// Reset: synchronous, active low; the token limit returns to 1024, no token pending.
// Stalls: the front holds a byte that needs a job while the two-job queue is full,
// or one that starts a token while the text bank it must write is still being drained.

module char_stream_tokenizer import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_text_char,
  output logic        out_last_in_token,
  output logic        out_last_in_run,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] token_limit_r;

  // Jobs from front to back, text memory writes and bank release.
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;
  wr_t  mem_wr;
  rel_t rel;

  // Token limit; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_limit_r <= TOKEN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      token_limit_r <= cfg_wr_data;
    end
  end

  // Front: classify each byte, advance the pending token, queue emit jobs.
  cst_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .token_limit     (token_limit_r),
    .cmd_push        (cmd_push),
    .cmd_data        (cmd_in),
    .cmd_full        (cmd_full),
    .mem_wr          (mem_wr),
    .rel             (rel)
  );

  // Decouple the two sides so a stalled output does not hold up byte intake.
  cst_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  // Back: drain each job one character per transfer.
  cst_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_wr            (mem_wr),
    .cmd_empty         (cmd_empty),
    .cmd_head          (cmd_head),
    .cmd_pop           (cmd_pop),
    .rel               (rel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_text_char     (out_text_char),
    .out_last_in_token (out_last_in_token),
    .out_last_in_run   (out_last_in_run)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for char_stream_tokenizer: directed and random byte streams.
// Carries its own token predictor; depends only on cst_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb;
  import cst_pkg::*;

  // Cycles to let pass after the last expected character before the block
  // counts as idle: a memory fetch plus a full token of text, with margin.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Watchdog, in ns; the clock period is 2 ns.
  localparam longint unsigned RUN_LIMIT_NS = 2_000_000;
  // Bytes of the keyword, first character in the top byte.
  localparam logic [39:0] KEYWORD_TEXT = "print";
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One expected character of token text as it leaves the block.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] text;
    logic       tok_end;
    logic       run_end;
  } token_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_text_char;
  logic        out_last_in_token;
  logic        out_last_in_run;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // Shaping of the traffic, changed per phase, and running counts.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;

  // Predictor state: pending token text and the token counter.
  logic [7:0]  pend_text [BUF_DEPTH];
  int unsigned pend_len;
  pend_t       pend_kind;
  logic [15:0] tok_count;
  logic [15:0] tok_limit;

  token_char_t expected_chars[$];

  char_stream_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_text_char    (out_text_char),
    .out_last_in_token(out_last_in_token),
    .out_last_in_run  (out_last_in_run),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Receiver: stall the result channel at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------

  function automatic logic byte_is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic byte_is_numeral(logic [7:0] c);
    return (c >= "0" && c <= "9");
  endfunction

  function automatic void push_char(kind_t kind, logic [7:0] text, logic tok_end);
    token_char_t tc;
    tc.kind    = kind;
    tc.text    = text;
    tc.tok_end = tok_end;
    tc.run_end = 1'b0;
    expected_chars.push_back(tc);
  endfunction

  // Emit the buffered identifier or number, one character per result.
  function automatic void flush_pending_token();
    kind_t kind;
    logic  is_kw;
    if (pend_kind != PEND_NONE && pend_len != 0) begin
      kind = (pend_kind == PEND_IDENT) ? KIND_IDENT : KIND_NUMBER;
      if (pend_kind == PEND_IDENT && pend_len == 5) begin
        is_kw = 1'b1;
        for (int i = 0; i < 5; i++)
          if (pend_text[i] != KEYWORD_TEXT[39 - 8*i -: 8]) is_kw = 1'b0;
        if (is_kw) kind = KIND_PRINT;
      end
      for (int i = 0; i < pend_len; i++)
        push_char(kind, pend_text[i], (i + 1 == pend_len));
      tok_count = tok_count + 16'd1;
    end
    pend_kind = PEND_NONE;
    pend_len  = 0;
  endfunction

  // Work out the characters caused by one accepted byte.
  function automatic void predict_tokens(logic [7:0] c, logic eoi);
    int unsigned first;
    logic        extend;
    token_char_t tail;
    first  = expected_chars.size();
    extend = 1'b0;
    if (eoi) begin
      flush_pending_token();
      push_char(KIND_END, CH_NUL, 1'b1);
      tok_count = 16'd0;
    end else begin
      if (pend_kind != PEND_NONE) begin
        extend = (pend_kind == PEND_IDENT) ? (byte_is_alpha(c) || byte_is_numeral(c))
                                           : byte_is_numeral(c);
        // A full buffer splits the token; the byte then starts a new one if under the limit.
        if (extend && pend_len < BUF_DEPTH) begin
          pend_text[pend_len] = c;
          pend_len++;
        end else begin
          extend = 1'b0;
          flush_pending_token();
        end
      end
      if (!extend && tok_count < tok_limit) begin
        if (byte_is_alpha(c) || byte_is_numeral(c)) begin
          pend_kind    = byte_is_alpha(c) ? PEND_IDENT : PEND_NUMBER;
          pend_text[0] = c;
          pend_len     = 1;
        end else if (c == CH_ASSIGN) begin
          push_char(KIND_ASSIGN, c, 1'b1);
          tok_count = tok_count + 16'd1;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
          push_char(KIND_OPERATOR, c, 1'b1);
          tok_count = tok_count + 16'd1;
        end
      end
    end
    // Mark the last character of this byte's burst.
    if (expected_chars.size() > first) begin
      tail = expected_chars.pop_back();
      tail.run_end = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  function automatic void check_token_char();
    token_char_t want;
    if (expected_chars.size() == 0) begin
      mismatch_count++;
      $display("%0t: result expected none actual kind=%0d char=%02h last_tok=%0b last_run=%0b",
               $realtime, out_token_kind, out_text_char, out_last_in_token,
               out_last_in_run);
    end else begin
      want = expected_chars.pop_front();
      if (out_token_kind != want.kind) begin
        mismatch_count++;
        $display("%0t: token_kind expected %0d actual %0d", $realtime, want.kind,
                 out_token_kind);
      end
      if (out_text_char != want.text) begin
        mismatch_count++;
        $display("%0t: text_char expected %02h actual %02h", $realtime, want.text,
                 out_text_char);
      end
      if (out_last_in_token != want.tok_end) begin
        mismatch_count++;
        $display("%0t: last_in_token expected %0b actual %0b", $realtime, want.tok_end,
                 out_last_in_token);
      end
      if (out_last_in_run != want.run_end) begin
        mismatch_count++;
        $display("%0t: last_in_run expected %0b actual %0b", $realtime, want.run_end,
                 out_last_in_run);
      end
    end
  endfunction

  // Monitor: track config writes, predict on each input transfer, then check
  // each result transfer, all on the same edge so the order is fixed.
  always @(posedge clk) begin
    if (!rst_n) begin
      pend_len  = 0;
      pend_kind = PEND_NONE;
      tok_count = 16'd0;
      tok_limit = TOKEN_LIMIT_RESET;
    end else begin
      if (cfg_wr_en) tok_limit = cfg_wr_data;
      if (in_valid && !in_stall) predict_tokens(in_byte, in_end_of_input);
      if (out_valid && !out_stall) check_token_char();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Drive one byte and hold it until the transfer. Valid is left high so
  // the next call can chain without a bubble.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Drop valid and hold until every expected character has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Write the token limit once the block has gone quiet.
  task automatic write_token_limit(input logic [15:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("A") + 8'($urandom_range(25))
                             : 8'("a") + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_numeral();
    return 8'("0") + 8'($urandom_range(9));
  endfunction

  // Send one lexical piece of a plausible source line, or some noise.
  task automatic send_random_piece();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    // Mostly short tokens; now and then a long one that can hit the split.
    len = ($urandom_range(19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
    if (pick < 25) begin
      send_item(rand_letter(), 1'b0);
      for (int i = 1; i < len; i++)
        send_item(($urandom_range(3) == 0) ? rand_numeral() : rand_letter(), 1'b0);
    end else if (pick < 40) begin
      for (int i = 0; i < len; i++) send_item(rand_numeral(), 1'b0);
    end else if (pick < 48) begin
      case ($urandom_range(3))
        0: send_text("print");
        1: send_text("prints");
        2: send_text("prin");
        default: send_text("Print");
      endcase
    end else if (pick < 60) begin
      case ($urandom_range(3))
        0: send_item(CH_PLUS, 1'b0);
        1: send_item(CH_MINUS, 1'b0);
        2: send_item(CH_STAR, 1'b0);
        default: send_item(CH_SLASH, 1'b0);
      endcase
    end else if (pick < 68) begin
      send_item(CH_ASSIGN, 1'b0);
    end else if (pick < 83) begin
      case ($urandom_range(3))
        0: send_item(CH_SPACE, 1'b0);
        1: send_item(CH_TAB, 1'b0);
        2: send_item(CH_LF, 1'b0);
        default: send_item(CH_CR, 1'b0);
      endcase
    end else if (pick < 97) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Random source text of about count bytes, closed by an end of input.
  // Optionally pause midway until the block has emptied.
  task automatic send_random_source(input int unsigned count, input logic pause_midway);
    int unsigned target;
    int unsigned midpoint;
    target   = bytes_sent + count;
    midpoint = bytes_sent + count / 2;
    while (bytes_sent < target) begin
      send_random_piece();
      if (pause_midway && bytes_sent >= midpoint) begin
        wait_drain();
        pause_midway = 1'b0;
      end
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every token kind, skipped bytes at the top and bottom of the range,
  // end of input with no token pending. Default limit.
  task automatic test_token_kinds();
    set_traffic(0, 0);
    send_text("print x1=42+y*7/0-Zz9");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  // Tokens at and beyond the buffer length: split on the extra byte and
  // full-length flushes that produce the largest bursts.
  task automatic test_length_limit();
    set_traffic(0, 0);
    for (int i = 0; i < BUF_DEPTH + 1; i++) send_item(rand_letter(), 1'b0);
    send_item(CH_PLUS, 1'b0);
    for (int i = 0; i < BUF_DEPTH + 2; i++) send_item(rand_numeral(), 1'b0);
    send_item(CH_ASSIGN, 1'b0);
    for (int i = 0; i < BUF_DEPTH; i++) send_item(rand_letter(), 1'b0);
    send_item(8'h00, 1'b1);
    for (int i = 0; i < BUF_DEPTH; i++) send_item(rand_numeral(), 1'b0);
    send_item(CH_MINUS, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // Zero limit, a limit reached mid-line, and a limit lowered under a
  // pending token, which must still complete.
  task automatic test_token_limit();
    set_traffic(0, 0);
    write_token_limit(16'd0);
    send_text("a=1+ b");
    send_item(8'h00, 1'b1);
    write_token_limit(16'd3);
    send_text("a=b+c");
    send_item(8'h00, 1'b1);
    write_token_limit(16'd5);
    send_text("x = abc");
    write_token_limit(16'd0);
    send_text(" +q");
    send_item(8'h00, 1'b1);
  endtask

  // Random source under each traffic pattern and a spread of limits.
  task automatic test_random_sources();
    write_token_limit(16'hFFFF);
    set_traffic(0, 0);
    send_random_source(45, 1'b0);
    write_token_limit(16'($urandom_range(2, 30)));
    set_traffic(74, 0);
    send_random_source(45, 1'b1);
    write_token_limit(16'($urandom_range(65535)));
    set_traffic(0, 74);
    send_random_source(45, 1'b0);
    write_token_limit(16'($urandom_range(1, 12)));
    set_traffic(21, 21);
    send_random_source(45, 1'b0);
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_token_kinds();
    test_length_limit();
    test_token_limit();
    test_random_sources();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
